[sv/md5_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MD5 package
// Shared types and constants for the MD5 digest block.
// ---------------------------------------------------------------------------
package md5_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned WordCount  = 16;
    localparam int unsigned FillW      = 6;
    localparam int unsigned LenW       = 61;

    localparam logic [31:0] InitA = 32'h67452301;
    localparam logic [31:0] InitB = 32'hefcdab89;
    localparam logic [31:0] InitC = 32'h98badcfe;
    localparam logic [31:0] InitD = 32'h10325476;

    localparam logic [7:0]  PadByte    = 8'h80;
    localparam logic [5:0]  LenOffset  = 6'd56;

    typedef logic [31:0] t_word;

    function automatic t_word round_const(input logic [5:0] r);
        t_word k;
        case (r)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'b0000: s = 5'd7;  4'b0001: s = 5'd12; 4'b0010: s = 5'd17; 4'b0011: s = 5'd22;
            4'b0100: s = 5'd5;  4'b0101: s = 5'd9;  4'b0110: s = 5'd14; 4'b0111: s = 5'd20;
            4'b1000: s = 5'd4;  4'b1001: s = 5'd11; 4'b1010: s = 5'd16; 4'b1011: s = 5'd23;
            4'b1100: s = 5'd6;  4'b1101: s = 5'd10; 4'b1110: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Message word used by a round.
    function automatic logic [3:0] word_sel(input logic [5:0] r);
        logic [3:0] g;
        case (r[5:4])
            2'd0:    g = r[3:0];
            2'd1:    g = 4'(5 * r[3:0] + 1);
            2'd2:    g = 4'(3 * r[3:0] + 5);
            default: g = 4'(7 * r[3:0]);
        endcase
        return g;
    endfunction

endpackage

[sv/md5_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MD5 generic RAM
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module md5_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/md5_message_digest_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MD5 message digest top level
// Byte-serial MD5 hash with a word-wide block store and an iterative round.
// ---------------------------------------------------------------------------
// Bytes enter one per transaction and are packed into a 16 x 32-bit block RAM
// (little-endian inside each word). After a byte that does not fill the
// block the sequencer stays idle for the next byte. A byte that fills the
// block starts the compression: 64 rounds, each one a RAM read of the message
// word (S_RREQ) followed by one round update (S_ROUND), then the add into the
// chaining value (S_FOLD) and the decision (S_NEXT); no transaction is
// accepted meanwhile. The message ends with last_byte or message_empty.
// Padding words are then written into the RAM one per cycle, from the word
// that takes the 0x80 byte to the end of the block. One or two blocks are
// compressed after that. A message that needs a second block (pad byte at
// offset 56 or later, or a last byte that fills the block) writes a full
// second block of zeros and length, with the 0x80 byte in its first word when
// the last byte filled the block. S_OUT then moves the digest into the output
// register. The digest sits in its own output register, so the next message
// is accepted while it waits to be taken; only a second finished digest
// waits until the first has been taken. There is no clearing pass after reset.
// ---------------------------------------------------------------------------
module md5_message_digest_top
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_message_empty,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_first_half,
    output logic [63:0] o_digest_second_half
);
    // Sequencer states.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,  // write padding words
        S_RREQ  = 7'b0000100,  // issue word read
        S_ROUND = 7'b0001000,  // apply one round
        S_FOLD  = 7'b0010000,  // add into chaining value
        S_NEXT  = 7'b0100000,  // decide after a block
        S_OUT   = 7'b1000000   // digest waiting for the output register
    } t_state;

    t_state      r_state, n_state;
    t_word       r_h [4];
    t_word       r_a, r_b, r_c, r_d;
    logic [5:0]  r_fill;
    logic [LenW-1:0] r_len;
    logic [5:0]  r_round;
    logic [3:0]  r_pw;       // padding word index
    logic        r_fin;      // message end in progress
    logic        r_second;   // a further padding block follows
    logic        r_lenblk;   // current block carries the length
    logic [23:0] r_part;     // bytes of the partial word
    logic [63:0] r_dig0, r_dig1;
    logic        r_ovalid;   // output register holds a digest

    logic        we;
    logic [3:0]  waddr, raddr;
    t_word       wdata, rdata;

    md5_ram #(.Width(32), .Depth(WordCount)) u_block (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic accept;
    logic load_dig;
    logic [5:0] end_fill;
    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign load_dig = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    assign o_valid  = r_ovalid;
    assign o_digest_first_half  = r_dig0;
    assign o_digest_second_half = r_dig1;

    // Fill once the accepted transaction is taken in; the pad byte lands here.
    assign end_fill = i_message_empty ? r_fill : r_fill + 6'd1;

    // Padding content for word r_pw, built from the fill, partial bytes and length.
    logic [63:0] bits;
    t_word       pad_word;
    logic [3:0]  fw;
    assign bits = {r_len, 3'b000};
    assign fw   = r_fill[5:2];
    always_comb begin
        pad_word = '0;
        if (!r_lenblk || r_pw < 4'd14) begin
            if (r_pw == fw) begin
                case (r_fill[1:0])
                    2'd0:    pad_word = {24'h0, PadByte};
                    2'd1:    pad_word = {16'h0, PadByte, r_part[7:0]};
                    2'd2:    pad_word = {8'h0, PadByte, r_part[15:0]};
                    default: pad_word = {PadByte, r_part[23:0]};
                endcase
            end
        end
        if (r_lenblk && r_pw == 4'd14) pad_word = bits[31:0];
        if (r_lenblk && r_pw == 4'd15) pad_word = bits[63:32];
    end

    // Round logic.
    t_word f, sum, rot;
    logic [4:0] s;
    always_comb begin
        case (r_round[5:4])
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f = (r_d & r_b) | (~r_d & r_c);
            2'd2:    f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        sum = r_a + f + round_const(r_round) + rdata;
        s   = rot_amount(r_round);
        rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    end

    t_word nb;
    assign nb = r_b + rot;

    always_comb begin
        we      = 1'b0;
        waddr   = r_fill[5:2];
        wdata   = {i_data_byte, r_part};
        raddr   = word_sel(r_round);
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_message_empty) begin
                        n_state = S_PAD;
                    end else begin
                        we = (r_fill[1:0] == 2'd3);
                        if (r_fill == 6'd63) n_state = S_RREQ;
                        else if (i_last_byte) n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                we      = 1'b1;
                waddr   = r_pw;
                wdata   = pad_word;
                if (r_pw == 4'd15) n_state = S_RREQ;
            end
            S_RREQ:  n_state = S_ROUND;
            S_ROUND: n_state = (r_round == 6'd63) ? S_FOLD : S_RREQ;
            S_FOLD:  n_state = S_NEXT;
            S_NEXT: begin
                if (!r_fin) n_state = S_IDLE;
                else if (r_second) n_state = S_PAD;
                else n_state = S_OUT;
            end
            S_OUT:   if (load_dig) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_h[0]   <= InitA; r_h[1] <= InitB; r_h[2] <= InitC; r_h[3] <= InitD;
            r_fill   <= '0;
            r_len    <= '0;
            r_round  <= '0;
            r_pw     <= '0;
            r_fin    <= 1'b0;
            r_second <= 1'b0;
            r_lenblk <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= load_dig || (r_ovalid && i_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        // Padding starts at the word that takes the pad byte.
                        r_pw <= end_fill[5:2];
                        if (!i_message_empty) begin
                            r_fill <= r_fill + 6'd1;
                            r_len  <= r_len + LenW'(1);
                        end
                        if (i_message_empty || i_last_byte) begin
                            r_fin <= 1'b1;
                            // Fill after this byte decides one or two blocks.
                            if (!i_message_empty && r_fill == 6'd63) begin
                                r_second <= 1'b1;   // full block first
                                r_lenblk <= 1'b0;
                            end else if (!i_message_empty ?
                                         (r_fill + 6'd1 >= LenOffset) :
                                         (r_fill >= LenOffset)) begin
                                r_second <= 1'b1;
                                r_lenblk <= 1'b0;
                            end else begin
                                r_second <= 1'b0;
                                r_lenblk <= 1'b1;
                            end
                        end
                    end
                end
                S_PAD: r_pw <= r_pw + 4'd1;
                S_ROUND: begin
                    r_a     <= r_d;
                    r_d     <= r_c;
                    r_c     <= r_b;
                    r_b     <= nb;
                    r_round <= r_round + 6'd1;
                end
                S_FOLD: begin
                    r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                end
                S_NEXT: begin
                    r_pw <= '0;
                    if (r_fin && r_second) begin
                        // Next block: pad byte already placed unless the
                        // compressed block was a full data block.
                        r_second <= 1'b0;
                        r_lenblk <= 1'b1;
                        if (r_fill != 6'd0) r_fill <= 6'd63;
                    end
                end
                S_OUT: begin
                    // Move the digest out once the output register is free.
                    if (load_dig) begin
                        r_dig0 <= {r_h[1], r_h[0]};
                        r_dig1 <= {r_h[3], r_h[2]};
                        r_h[0] <= InitA; r_h[1] <= InitB;
                        r_h[2] <= InitC; r_h[3] <= InitD;
                        r_fill <= '0;
                        r_len  <= '0;
                        r_fin  <= 1'b0;
                        r_lenblk <= 1'b0;
                    end
                end
                default: ;
            endcase
            if (n_state == S_RREQ && r_state != S_ROUND) begin
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
                r_round <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_message_empty) begin
            case (r_fill[1:0])
                2'd0:    r_part[7:0]   <= i_data_byte;
                2'd1:    r_part[15:8]  <= i_data_byte;
                2'd2:    r_part[23:16] <= i_data_byte;
                default: ;
            endcase
        end
    end
endmodule
